FILE: design/onrk4_pkg.sv
package onrk4_pkg;

  // Default sizes, handed to the top level parameters
  localparam int NODES_DEF        = 8;
  localparam int EDGES_DEF        = 32;
  localparam int CORDIC_ITERS_DEF = 16;

  // Fixed field widths
  localparam int NODE_IDW = 6;
  localparam int RANGE_W  = 11;
  localparam int COUNT_W  = 7;
  localparam int ITER_W   = 5;

  // Angle constants, Q16.16
  localparam logic [19:0] TWO_PI    = 20'd411775;
  localparam logic [19:0] PI        = 20'd205887;
  localparam logic [19:0] HALF_PI   = 20'd102944;
  localparam logic [23:0] CORDIC_X0 = 24'd39797;

  // Range reduction walks 2pi << MOD_TOP down to 2pi << 0
  localparam logic [ITER_W-1:0] MOD_TOP = 5'd13;

  // Index of the last multiply step in one Runge-Kutta sweep
  localparam logic [ITER_W-1:0] RK_LAST = 5'd16;

  typedef enum logic [1:0] {
    FUNC_EDGE = 2'd0,
    FUNC_NODE = 2'd1,
    FUNC_STEP = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    REG_DAMPING    = 3'd0,
    REG_RESTORING  = 3'd1,
    REG_STEP_FULL  = 3'd2,
    REG_STEP_HALF  = 3'd3,
    REG_STEP_SIXTH = 3'd4,
    REG_NODE_COUNT = 3'd5
  } reg_t;

  // Multiply steps of the integrator
  typedef enum logic [3:0] {
    UOP_DW  = 4'd0,  // alpha * stage speed
    UOP_DT1 = 4'd1,  // gamma * stage phase, close derivative, weight 1
    UOP_DT2 = 4'd2,  // gamma * stage phase, close derivative, weight 2
    UOP_WH  = 4'd3,  // stage speed from kw * hh
    UOP_WF  = 4'd4,  // stage speed from kw * h
    UOP_TK  = 4'd5,  // stage phase and next kt from kt * hh
    UOP_TH  = 4'd6,  // stage phase from kt * hh
    UOP_KF  = 4'd7,  // last kt from kt * h
    UOP_NW  = 4'd8,  // new speed
    UOP_NT  = 4'd9   // new phase
  } uop_t;

  typedef struct packed {
    logic                take;
    logic                node_rd;
    logic                node_ld;
    logic                edge_rd;
    logic                far_rd;
    logic                diff_ld;
    logic                mod_step;
    logic                cordic_init;
    logic                cordic_step;
    logic                cpl_mul;
    logic                cpl_wb;
    logic                rk_mul;
    logic                rk_wb;
    uop_t                uop;
    logic [ITER_W-1:0]   iter;
    logic [NODE_IDW-1:0] node;
    logic                node_wr;
    logic                out_ld;
  } cmd_t;

  typedef struct packed {
    logic step_go;
    logic edge_more;
    logic last_node;
    logic out_busy;
  } sts_t;

  function automatic uop_t uop_at(input logic [ITER_W-1:0] i);
    uop_t u;
    case (i)
      5'd0, 5'd4, 5'd8, 5'd13: u = UOP_DW;
      5'd1, 5'd14:             u = UOP_DT1;
      5'd5, 5'd9:              u = UOP_DT2;
      5'd2, 5'd6:              u = UOP_WH;
      5'd3, 5'd7:              u = UOP_TK;
      5'd10:                   u = UOP_WF;
      5'd11:                   u = UOP_TH;
      5'd12:                   u = UOP_KF;
      5'd15:                   u = UOP_NW;
      5'd16:                   u = UOP_NT;
      default:                 u = UOP_DW;
    endcase
    return u;
  endfunction

  function automatic logic [15:0] atan_at(input logic [ITER_W-1:0] i);
    logic [15:0] a;
    case (i)
      5'd0:    a = 16'd51472;
      5'd1:    a = 16'd30386;
      5'd2:    a = 16'd16055;
      5'd3:    a = 16'd8150;
      5'd4:    a = 16'd4091;
      5'd5:    a = 16'd2047;
      5'd6:    a = 16'd1024;
      5'd7:    a = 16'd512;
      5'd8:    a = 16'd256;
      5'd9:    a = 16'd128;
      5'd10:   a = 16'd64;
      5'd11:   a = 16'd32;
      5'd12:   a = 16'd16;
      5'd13:   a = 16'd8;
      5'd14:   a = 16'd4;
      5'd15:   a = 16'd2;
      5'd16:   a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > $signed(48'h0000_7FFF_FFFF)) r = 32'sh7FFF_FFFF;
    else if (v < $signed(48'hFFFF_8000_0000)) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Q16.16 product: floor shift by 16, then saturate
  function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
    logic signed [47:0] sh;
    sh = p[63:16];
    return sat32(sh);
  endfunction

endpackage

FILE: design/onrk4_ctrl.sv
module onrk4_ctrl #(
  parameter int CORDIC_ITERS = onrk4_pkg::CORDIC_ITERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  onrk4_pkg::sts_t  sts,
  output onrk4_pkg::cmd_t  cmd
);
  import onrk4_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_NODE_RD  = 14'b00000000000010,
    S_NODE_LD  = 14'b00000000000100,
    S_EDGE_CHK = 14'b00000000001000,
    S_FAR_RD   = 14'b00000000010000,
    S_FAR_LD   = 14'b00000000100000,
    S_MOD      = 14'b00000001000000,
    S_CINIT    = 14'b00000010000000,
    S_CORDIC   = 14'b00000100000000,
    S_CPL_MUL  = 14'b00001000000000,
    S_CPL_WB   = 14'b00010000000000,
    S_RK_MUL   = 14'b00100000000000,
    S_RK_WB    = 14'b01000000000000,
    S_NODE_WR  = 14'b10000000000000
  } state_t;

  localparam logic [ITER_W-1:0] CORDIC_LAST = ITER_W'(CORDIC_ITERS - 1);

  state_t              state, state_next;
  logic [NODE_IDW-1:0] n, n_next;
  logic [ITER_W-1:0]   cnt, cnt_next;

  // Take requests in idle; sequence a step: node fetch, edge loop, integrator, write back
  always_comb begin
    cmd        = '0;
    cmd.node   = n;
    cmd.iter   = cnt;
    cmd.uop    = uop_at(cnt);
    state_next = state;
    n_next     = n;
    cnt_next   = cnt;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
        if (s_tvalid && sts.step_go) begin
          n_next     = '0;
          state_next = S_NODE_RD;
        end
      end
      S_NODE_RD: begin
        cmd.node_rd = 1'b1;
        state_next  = S_NODE_LD;
      end
      S_NODE_LD: begin
        cmd.node_ld = 1'b1;
        state_next  = S_EDGE_CHK;
      end
      S_EDGE_CHK: begin
        if (sts.edge_more) begin
          cmd.edge_rd = 1'b1;
          state_next  = S_FAR_RD;
        end else begin
          cnt_next   = '0;
          state_next = S_RK_MUL;
        end
      end
      S_FAR_RD: begin
        cmd.far_rd = 1'b1;
        state_next = S_FAR_LD;
      end
      S_FAR_LD: begin
        cmd.diff_ld = 1'b1;
        cnt_next    = MOD_TOP;
        state_next  = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (cnt == '0) state_next = S_CINIT;
        else cnt_next = cnt - 1'b1;
      end
      S_CINIT: begin
        cmd.cordic_init = 1'b1;
        cnt_next        = '0;
        state_next      = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (cnt == CORDIC_LAST) state_next = S_CPL_MUL;
        else cnt_next = cnt + 1'b1;
      end
      S_CPL_MUL: begin
        cmd.cpl_mul = 1'b1;
        state_next  = S_CPL_WB;
      end
      S_CPL_WB: begin
        cmd.cpl_wb = 1'b1;
        state_next = S_EDGE_CHK;
      end
      S_RK_MUL: begin
        cmd.rk_mul = 1'b1;
        state_next = S_RK_WB;
      end
      S_RK_WB: begin
        cmd.rk_wb = 1'b1;
        if (cnt == RK_LAST) begin
          state_next = S_NODE_WR;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = S_RK_MUL;
        end
      end
      S_NODE_WR: begin
        // Hold until the output register is free
        if (!sts.out_busy) begin
          cmd.node_wr = 1'b1;
          cmd.out_ld  = 1'b1;
          if (sts.last_node) begin
            state_next = S_IDLE;
          end else begin
            n_next     = n + 1'b1;
            state_next = S_NODE_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
      cnt   <= cnt_next;
    end
  end

endmodule

FILE: design/onrk4_dp.sv
module onrk4_dp #(
  parameter int NODES        = onrk4_pkg::NODES_DEF,
  parameter int EDGES        = onrk4_pkg::EDGES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [167:0]     s_tdata,
  input  logic [1:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [71:0]      m_tdata,
  output logic             m_tlast,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  input  onrk4_pkg::cmd_t  cmd,
  output onrk4_pkg::sts_t  sts
);
  import onrk4_pkg::*;

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int EW = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam logic [COUNT_W-1:0] NODES_C = COUNT_W'(NODES);
  localparam logic [RANGE_W-1:0] EDGES_C = RANGE_W'(EDGES);

  // Input item fields
  logic [9:0]          in_idx;
  logic [5:0]          in_far;
  logic signed [31:0]  in_gain, in_power, in_phase, in_speed;
  logic [RANGE_W-1:0]  in_first, in_end;

  assign in_idx   = s_tdata[9:0];
  assign in_far   = s_tdata[15:10];
  assign in_gain  = s_tdata[47:16];
  assign in_first = s_tdata[58:48];
  assign in_end   = s_tdata[69:59];
  assign in_power = s_tdata[101:70];
  assign in_phase = s_tdata[133:102];
  assign in_speed = s_tdata[165:134];

  // Configuration registers
  logic signed [31:0]  alpha, gamma;
  logic [30:0]         h_full, h_half, h_sixth;
  logic [COUNT_W-1:0]  node_count, cnt_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha      <= 32'sd6554;
      gamma      <= '0;
      h_full     <= 31'd655;
      h_half     <= 31'd328;
      h_sixth    <= 31'd109;
      node_count <= 7'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DAMPING:    alpha      <= cfg_data;
        REG_RESTORING:  gamma      <= cfg_data;
        REG_STEP_FULL:  h_full     <= cfg_data[30:0];
        REG_STEP_HALF:  h_half     <= cfg_data[30:0];
        REG_STEP_SIXTH: h_sixth    <= cfg_data[30:0];
        REG_NODE_COUNT: node_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cnt_eff = (node_count > NODES_C) ? NODES_C : node_count;

  // Write decode for load requests
  logic edge_we, node_we;
  assign edge_we = cmd.take && (s_tuser == FUNC_EDGE) && ({1'b0, in_idx} < EDGES_C);
  assign node_we = cmd.take && (s_tuser == FUNC_NODE) && ({4'b0, in_idx} < 14'(NODES));

  // Edge tables
  logic [5:0]         edge_far_mem [EDGES];
  logic signed [31:0] edge_wt_mem  [EDGES];
  logic [5:0]         e_far;
  logic signed [31:0] e_wt;
  logic [RANGE_W-1:0] j, j_end;

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_far_mem[in_idx[EW-1:0]] <= in_far;
      edge_wt_mem[in_idx[EW-1:0]]  <= in_gain;
    end
    if (cmd.edge_rd) begin
      e_far <= edge_far_mem[j[EW-1:0]];
      e_wt  <= edge_wt_mem[j[EW-1:0]];
    end
  end

  // Node tables; phase has a second read port for the far node
  logic [RANGE_W-1:0] start_mem [NODES];
  logic [RANGE_W-1:0] end_mem   [NODES];
  logic signed [31:0] pwr_mem   [NODES];
  logic signed [31:0] ph_mem    [NODES];
  logic signed [31:0] spd_mem   [NODES];
  logic [NODES-1:0]   nd_valid;

  logic [NW-1:0]      nd_wa, nd_ra;
  logic signed [31:0] nd_wph, nd_wspd;
  logic [RANGE_W-1:0] rd_start, rd_end;
  logic signed [31:0] rd_pwr, rd_ph, rd_spd, rd_far_ph;
  logic               rd_valid, rd_far_ok;
  logic signed [31:0] nw, nt;
  logic signed [31:0] w, t, p, s, kw, kt, wa, ta, m1;

  assign nd_ra   = cmd.node[NW-1:0];
  assign nd_wa   = cmd.node_wr ? nd_ra : in_idx[NW-1:0];
  assign nd_wph  = cmd.node_wr ? nt : in_phase;
  assign nd_wspd = cmd.node_wr ? nw : in_speed;

  always_ff @(posedge clk) begin
    if (node_we) begin
      start_mem[nd_wa] <= in_first;
      end_mem[nd_wa]   <= in_end;
      pwr_mem[nd_wa]   <= in_power;
    end
    if (node_we || cmd.node_wr) begin
      ph_mem[nd_wa]  <= nd_wph;
      spd_mem[nd_wa] <= nd_wspd;
    end
    if (cmd.node_rd) begin
      rd_start <= start_mem[nd_ra];
      rd_end   <= end_mem[nd_ra];
      rd_pwr   <= pwr_mem[nd_ra];
      rd_ph    <= ph_mem[nd_ra];
      rd_spd   <= spd_mem[nd_ra];
      rd_valid <= nd_valid[nd_ra];
    end
    if (cmd.far_rd) begin
      rd_far_ph <= ph_mem[e_far[NW-1:0]];
      rd_far_ok <= ({1'b0, e_far} < NODES_C) && nd_valid[e_far[NW-1:0]];
    end
  end

  // Phase and speed read as zero until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      nd_valid <= '0;
    end else if (node_we || cmd.node_wr) begin
      nd_valid[nd_wa] <= 1'b1;
    end
  end

  // Range reduction of the phase difference, one multiple of 2pi a cycle
  logic [31:0]        mag;
  logic               neg;
  logic signed [31:0] diff;
  logic [33:0]        mod_cand;

  assign diff     = sat32(48'(t) - 48'(rd_far_ok ? rd_far_ph : 32'sd0));
  assign mod_cand = 34'(TWO_PI) << cmd.iter;

  always_ff @(posedge clk) begin
    if (cmd.diff_ld) begin
      neg <= diff[31];
      mag <= diff[31] ? 32'(-33'(diff)) : 32'(diff);
    end else if (cmd.mod_step) begin
      if ({2'b0, mag} >= mod_cand) mag <= 32'({2'b0, mag} - mod_cand);
    end
  end

  // Fold remainder into [-pi/2, pi/2]
  logic signed [21:0] z0;
  always_comb begin
    logic signed [21:0] r;
    r = neg ? -22'(mag[19:0]) : 22'(mag[19:0]);
    if (r >= $signed(22'(PI))) r = r - $signed(22'(TWO_PI));
    if (r < -$signed(22'(PI))) r = r + $signed(22'(TWO_PI));
    if (r > $signed(22'(HALF_PI))) r = $signed(22'(PI)) - r;
    if (r < -$signed(22'(HALF_PI))) r = -$signed(22'(PI)) - r;
    z0 = r;
  end

  // CORDIC rotation, one iteration a cycle
  logic signed [23:0] cx, cy;
  logic signed [21:0] cz;
  logic signed [21:0] atan_v;
  assign atan_v = $signed(22'(atan_at(cmd.iter)));

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      cx <= $signed(CORDIC_X0);
      cy <= '0;
      cz <= z0;
    end else if (cmd.cordic_step) begin
      if (!cz[21]) begin
        cx <= cx - (cy >>> cmd.iter);
        cy <= cy + (cx >>> cmd.iter);
        cz <= cz - atan_v;
      end else begin
        cx <= cx + (cy >>> cmd.iter);
        cy <= cy - (cx >>> cmd.iter);
        cz <= cz + atan_v;
      end
    end
  end

  // Shared multiplier and its operand select
  logic signed [35:0] accw, acct;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] q;

  always_comb begin
    mul_a = e_wt;
    mul_b = {{8{cy[23]}}, cy};
    if (!cmd.cpl_mul) begin
      case (cmd.uop)
        UOP_DW:           begin mul_a = alpha; mul_b = wa; end
        UOP_DT1, UOP_DT2: begin mul_a = gamma; mul_b = ta; end
        UOP_WH:           begin mul_a = kw;    mul_b = {1'b0, h_half}; end
        UOP_WF:           begin mul_a = kw;    mul_b = {1'b0, h_full}; end
        UOP_TK, UOP_TH:   begin mul_a = kt;    mul_b = {1'b0, h_half}; end
        UOP_KF:           begin mul_a = kt;    mul_b = {1'b0, h_full}; end
        UOP_NW:           begin mul_a = {1'b0, h_sixth}; mul_b = sat32(48'(accw)); end
        UOP_NT:           begin mul_a = {1'b0, h_sixth}; mul_b = sat32(48'(acct)); end
        default:          begin mul_a = alpha; mul_b = wa; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cpl_mul || cmd.rk_mul) prod <= mul_a * mul_b;
  end

  assign q = qsat(prod);

  // Node state load, and writeback of integrator and coupling results
  logic signed [31:0] deriv, w_plus, t_plus;
  assign deriv  = sat32(48'(p) - 48'(m1) - 48'(q) - 48'(s));
  assign w_plus = sat32(48'(w) + 48'(q));
  assign t_plus = sat32(48'(t) + 48'(q));

  always_ff @(posedge clk) begin
    if (cmd.node_ld) begin
      w     <= rd_valid ? rd_spd : 32'sd0;
      t     <= rd_valid ? rd_ph : 32'sd0;
      wa    <= rd_valid ? rd_spd : 32'sd0;
      ta    <= rd_valid ? rd_ph : 32'sd0;
      kt    <= rd_valid ? rd_spd : 32'sd0;
      acct  <= rd_valid ? 36'(rd_spd) : 36'sd0;
      accw  <= '0;
      p     <= rd_pwr;
      s     <= '0;
      j     <= rd_start;
      j_end <= rd_end;
    end else if (cmd.cpl_wb) begin
      s <= sat32(48'(s) + 48'(q));
      j <= j + 1'b1;
    end else if (cmd.rk_wb) begin
      case (cmd.uop)
        UOP_DW: m1 <= q;
        UOP_DT1: begin
          kw   <= deriv;
          accw <= accw + 36'(deriv);
        end
        UOP_DT2: begin
          kw   <= deriv;
          accw <= accw + 36'(deriv) + 36'(deriv);
        end
        UOP_WH, UOP_WF: wa <= w_plus;
        UOP_TK: begin
          ta   <= t_plus;
          kt   <= w_plus;
          acct <= acct + 36'(w_plus) + 36'(w_plus);
        end
        UOP_TH: ta <= t_plus;
        UOP_KF: begin
          kt   <= w_plus;
          acct <= acct + 36'(w_plus);
        end
        UOP_NW: nw <= w_plus;
        UOP_NT: nt <= t_plus;
        default: ;
      endcase
    end
  end

  // Output register
  logic [NODE_IDW-1:0] out_node;
  logic signed [31:0]  out_ph, out_spd;
  logic                out_last, out_valid;

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_node <= cmd.node;
      out_ph   <= nt;
      out_spd  <= nw;
      out_last <= sts.last_node;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {2'b00, out_spd, out_ph, out_node};

  // Status to the controller
  assign sts.step_go   = (s_tuser == FUNC_STEP) && (cnt_eff != '0);
  assign sts.edge_more = (j < j_end) && (j < EDGES_C);
  assign sts.last_node = ({1'b0, cmd.node} + 7'd1) == cnt_eff;
  assign sts.out_busy  = out_valid && !m_tready;

endmodule

FILE: design/oscillator_network_rk4_step_top.sv
// Coupled phase oscillator network, one Runge-Kutta sweep per step request.
//
// Input stream (s_*): s_tuser carries the function: edge load, node load or
// step. Loads write the edge or node tables and give no result; a step
// updates nodes 0 to min(node_count, NODES)-1 in order, in place, and
// returns one result per node on the output stream (m_*), with m_tlast on
// the final node. The user must write configuration (cfg_*) only while
// the block is idle; the block itself does not enforce this.
//
// Per node a step fetches the node, runs the range reduction and the CORDIC
// (one iteration a cycle) for each edge, where these two dominate, and then
// the integrator: 17 products on one shared 32x32 multiplier. A load leaves
// the block idle. Requests are taken one at a time.
//
// Reset clears configuration to defaults, phases and speeds to zero and
// drops any pending result. When the receiver stalls, the finished result
// holds in the output register and the sweep waits at the next write back.
module oscillator_network_rk4_step_top #(
  parameter int NODES        = onrk4_pkg::NODES_DEF,
  parameter int EDGES        = onrk4_pkg::EDGES_DEF,
  parameter int CORDIC_ITERS = onrk4_pkg::CORDIC_ITERS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // entry_index, neighbor_node, edge_gain, first_edge, end_edge,
  // node_power, phase_init, speed_init
  input  logic [167:0] s_tdata,
  // func
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // node_id, phase_out, speed_out
  output logic [71:0]  m_tdata,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import onrk4_pkg::*;

  cmd_t cmd;
  sts_t sts;

  onrk4_ctrl #(
    .CORDIC_ITERS(CORDIC_ITERS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  onrk4_dp #(
    .NODES        (NODES),
    .EDGES        (EDGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // No result survives a reset
  a_reset_clears_out: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result pending right after reset");

  // While idle, only the final result of a step may still wait
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tlast))
    else $error("idle with a non-final result pending");

  // A load or an unused function returns to idle at once
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser != FUNC_STEP)) |=> s_tready)
    else $error("load request did not finish in one cycle");

endmodule

FILE: tb/oscillator_network_rk4_step_checker.sv
`timescale 1ns / 100ps

module oscillator_network_rk4_step_checker #(
  parameter int NODES        = onrk4_pkg::NODES_DEF,
  parameter int EDGES        = onrk4_pkg::EDGES_DEF,
  parameter int CORDIC_ITERS = onrk4_pkg::CORDIC_ITERS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [167:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [71:0]  m_tdata,
  input  logic         m_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending_results,
  output int           checked_results
);
  import onrk4_pkg::*;

  typedef struct {
    logic [5:0]  id;
    logic [31:0] phase;
    logic [31:0] speed;
    logic        last;
  } node_update_t;

  localparam longint ATAN_Q [24] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

  node_update_t node_updates_q[$];

  // Shadow of the block's tables and settings
  logic [5:0] far_node [EDGES];
  longint     edge_w   [EDGES];
  int         rng_lo   [NODES];
  int         rng_hi   [NODES];
  longint     power    [NODES];
  longint     phase    [NODES];
  longint     speed    [NODES];
  longint     alpha, gamma, h_full, h_half, h_sixth;
  int         nodes_used;

  // Publish the queue depth between clock edges
  always @(negedge clk) pending_results = node_updates_q.size();

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fxmul(longint a, longint b);
    return clamp32((a * b) >>> 16);
  endfunction

  function automatic longint cordic_sine(longint ang);
    longint r, x, y, z, dx, dy;
    r = ang % longint'(TWO_PI);
    if (r >= longint'(PI)) r -= longint'(TWO_PI);
    if (r < -longint'(PI)) r += longint'(TWO_PI);
    // fold into the right half plane
    if (r > longint'(HALF_PI)) r = longint'(PI) - r;
    if (r < -longint'(HALF_PI)) r = -longint'(PI) - r;
    x = longint'(CORDIC_X0);
    y = 0;
    z = r;
    for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q[i];
      end
    end
    return y;
  endfunction

  function automatic longint swing_deriv(longint w, longint t, longint p, longint s);
    return clamp32(p - fxmul(alpha, w) - fxmul(gamma, t) - s);
  endfunction

  // Sweep the first min(nodes_used, NODES) nodes in place and queue one update per node
  task automatic sweep_network();
    int cnt, fn;
    longint w, t, p, s, ff;
    longint k1w, k1t, k2w, k2t, k3w, k3t, k4w, k4t, acc;
    node_update_t u;
    cnt = (nodes_used > NODES) ? NODES : nodes_used;
    for (int n = 0; n < cnt; n++) begin
      w = speed[n]; t = phase[n]; p = power[n]; s = 0;
      for (int j = rng_lo[n]; j < rng_hi[n]; j++) begin
        if (j >= EDGES) continue;
        fn = far_node[j];
        ff = (fn < NODES) ? phase[fn] : 0;
        s = clamp32(s + fxmul(edge_w[j], cordic_sine(clamp32(t - ff))));
      end
      k1w = swing_deriv(w, t, p, s);
      k1t = w;
      k2w = swing_deriv(clamp32(w + fxmul(k1w, h_half)), clamp32(t + fxmul(k1t, h_half)), p, s);
      k2t = clamp32(w + fxmul(k1t, h_half));
      k3w = swing_deriv(clamp32(w + fxmul(k2w, h_half)), clamp32(t + fxmul(k2t, h_half)), p, s);
      k3t = clamp32(w + fxmul(k2t, h_half));
      k4w = swing_deriv(clamp32(w + fxmul(k3w, h_full)), clamp32(t + fxmul(k3t, h_half)), p, s);
      k4t = clamp32(w + fxmul(k3t, h_full));
      acc = clamp32(k1w + 2 * k2w + 2 * k3w + k4w);
      speed[n] = clamp32(w + fxmul(h_sixth, acc));
      acc = clamp32(k1t + 2 * k2t + 2 * k3t + k4t);
      phase[n] = clamp32(t + fxmul(h_sixth, acc));
      u.id = n[5:0];
      u.phase = phase[n][31:0];
      u.speed = speed[n][31:0];
      u.last = (n + 1 == cnt);
      node_updates_q.push_back(u);
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  initial begin
    fail_count = 0;
    checked_results = 0;
  end

  // Track requests and settings
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        phase[i] = 0;
        speed[i] = 0;
      end
      alpha = 6554; gamma = 0; h_full = 655; h_half = 328; h_sixth = 109;
      nodes_used = 8;
      node_updates_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_t'(cfg_index))
          REG_DAMPING:    alpha = longint'($signed(cfg_data));
          REG_RESTORING:  gamma = longint'($signed(cfg_data));
          REG_STEP_FULL:  h_full = longint'(cfg_data[30:0]);
          REG_STEP_HALF:  h_half = longint'(cfg_data[30:0]);
          REG_STEP_SIXTH: h_sixth = longint'(cfg_data[30:0]);
          REG_NODE_COUNT: nodes_used = int'(cfg_data[6:0]);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          FUNC_EDGE: if (s_tdata[9:0] < EDGES) begin
            far_node[s_tdata[9:0]] = s_tdata[15:10];
            edge_w[s_tdata[9:0]] = longint'($signed(s_tdata[47:16]));
          end
          FUNC_NODE: if (s_tdata[9:0] < NODES) begin
            rng_lo[s_tdata[9:0]] = int'(s_tdata[58:48]);
            rng_hi[s_tdata[9:0]] = int'(s_tdata[69:59]);
            power[s_tdata[9:0]] = longint'($signed(s_tdata[101:70]));
            phase[s_tdata[9:0]] = longint'($signed(s_tdata[133:102]));
            speed[s_tdata[9:0]] = longint'($signed(s_tdata[165:134]));
          end
          FUNC_STEP: sweep_network();
          default: ;
        endcase
      end
    end
  end

  // Compare each update against the oldest prediction
  always @(posedge clk) begin
    node_update_t u;
    if (!rst && m_tvalid && m_tready) begin
      if (node_updates_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result for node %0d", $realtime, m_tdata[5:0]);
      end else begin
        u = node_updates_q.pop_front();
        checked_results++;
        if (m_tdata[5:0] !== u.id) report("node_id", 32'(m_tdata[5:0]), 32'(u.id));
        if (m_tdata[37:6] !== u.phase) report("phase_out", m_tdata[37:6], u.phase);
        if (m_tdata[69:38] !== u.speed) report("speed_out", m_tdata[69:38], u.speed);
        if (m_tlast !== u.last) report("last", 32'(m_tlast), 32'(u.last));
      end
    end
  end

endmodule

FILE: tb/oscillator_network_rk4_step_top_tb.sv
`timescale 1ns / 100ps

module oscillator_network_rk4_step_top_tb;
  import onrk4_pkg::*;

  localparam int NODES = NODES_DEF;
  localparam int EDGES = EDGES_DEF;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [167:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [71:0]  m_tdata;
  logic         m_tlast;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           fail_count;
  int           pending_results;
  int           checked_results;
  int           sent_requests;
  int           step_requests;
  bit           send_burst;
  bit           recv_burst;

  oscillator_network_rk4_step_top i_dut (.*);

  oscillator_network_rk4_step_checker #(
    .NODES(NODES), .EDGES(EDGES), .CORDIC_ITERS(CORDIC_ITERS_DEF)
  ) i_checker (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [167:0] pack_req(
    logic [9:0] idx, logic [5:0] nb, logic [31:0] gain, logic [10:0] fe,
    logic [10:0] ee, logic [31:0] pw, logic [31:0] ph, logic [31:0] sp);
    return {2'b00, sp, ph, pw, ee, fe, gain, nb, idx};
  endfunction

  // Offer one request after a random gap and hold until it is taken
  task automatic send(logic [1:0] fn, logic [167:0] d);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    sent_requests++;
    if (fn == FUNC_STEP) step_requests++;
  endtask

  // Drop valid and wait until every predicted update has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] a, logic [31:0] g, logic [31:0] hf,
                              logic [31:0] hh, logic [31:0] h6, logic [31:0] cnt);
    logic [31:0] vals [6];
    vals = '{a, g, hf, hh, h6, cnt};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endcase
  endfunction

  // Random request: mostly well-formed loads and steps, some noise
  task automatic send_random();
    int sel;
    logic [10:0] fe, ee;
    logic [9:0]  idx;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      idx = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, EDGES - 1));
      send(FUNC_EDGE, pack_req(idx,
           $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, NODES - 1)),
           rand_q(), 11'($urandom), 11'($urandom), $urandom, $urandom, $urandom));
    end else if (sel < 70) begin
      idx = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, NODES - 1));
      if ($urandom_range(0, 19) == 0) begin
        fe = 11'($urandom);
        ee = 11'($urandom);
      end else begin
        fe = 11'($urandom_range(0, EDGES + 2));
        ee = ($urandom_range(0, 9) == 0) ? fe - 11'($urandom_range(1, 3))
                                         : fe + 11'($urandom_range(0, 4));
      end
      send(FUNC_NODE, pack_req(idx, 6'($urandom), $urandom, fe, ee,
                               rand_q(), rand_q(), rand_q()));
    end else if (sel < 96) begin
      send(FUNC_STEP, 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
    end else begin
      send(2'd3, 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
    end
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
      send_random();
    end
    send_burst = 1'b0;
  endtask

  // Receiver: random stall before each update, with occasional stall-free runs
  initial begin
    int gap;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_burst = ~recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    sent_requests = 0;
    step_requests = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tuser   <= FUNC_EDGE;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_DAMPING;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill both tables so every entry is defined before any sweep
    for (int j = 0; j < EDGES; j++)
      send(FUNC_EDGE, pack_req(10'(j), 6'($urandom_range(0, NODES - 1)),
                               rand_q(), '0, '0, '0, '0, '0));
    for (int n = 0; n < NODES; n++)
      send(FUNC_NODE, pack_req(10'(n), '0, '0, 11'(n * 4), 11'(n * 4 + 3),
                               rand_q(), rand_q(), rand_q()));

    // Directed: field extremes, out-of-range loads, odd ranges, unused function
    send(FUNC_STEP, '0);
    send(FUNC_EDGE, pack_req(10'd0, 6'd63, 32'h8000_0000, '0, '0, '0, '0, '0));
    send(FUNC_EDGE, pack_req(10'd1, 6'd0, 32'h7FFF_FFFF, '1, '1, '1, '1, '1));
    send(FUNC_EDGE, pack_req(10'(EDGES), 6'd1, 32'hFFFF_FFFF, '0, '0, '0, '0, '0));
    send(FUNC_EDGE, pack_req(10'd1023, 6'd2, 32'h1234_5678, '0, '0, '0, '0, '0));
    send(FUNC_NODE, pack_req(10'd0, '0, '0, 11'd0, 11'd2, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send(FUNC_NODE, pack_req(10'd1, '1, '1, 11'd5, 11'd2, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000));
    send(FUNC_NODE, pack_req(10'd2, '0, '0, 11'd30, 11'd1024, 32'h0001_0000,
                             32'h0003_243F, 32'hFFFF_0000));
    send(FUNC_NODE, pack_req(10'd3, '0, '0, 11'd7, 11'd7, '0, 32'hFFFC_DBC1, '0));
    send(FUNC_NODE, pack_req(10'(NODES), '0, '0, 11'd0, 11'd1, '0, '0, '0));
    send(FUNC_NODE, pack_req(10'd1023, '0, '0, 11'd0, 11'd1, '0, '0, '0));
    send(FUNC_NODE, pack_req(10'd4, '0, '0, 11'd2047, 11'd2047, '1, '0, '0));
    send(FUNC_NODE, pack_req(10'd5, '0, '0, 11'd28, 11'd32, '0, '0, '0));
    send(2'd3, '1);
    send(FUNC_STEP, '1);
    send(FUNC_STEP, '0);

    run_random(90);
    drain();

    // Saturating gains, largest steps, node count beyond the table
    program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'd64);
    run_random(80);
    drain();

    // Opposite extremes, zero steps, then no nodes at all
    program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
    run_random(40);
    drain();

    program_regs($urandom, $urandom, 32'd1, 32'd1, 32'd1, 32'd1);
    run_random(60);
    drain();

    program_regs(32'($urandom_range(0, 1 << 17)), 32'($urandom_range(0, 1 << 17)),
                 32'd3277, 32'd1638, 32'd546, 32'($urandom_range(2, NODES - 1)));
    run_random(60);
    drain();

    program_regs(32'd6554, 32'd13107, 32'd655, 32'd328, 32'd109, 32'd127);
    run_random(90);
    drain();

    $display("Sent %0d requests (%0d sweeps), checked %0d node updates",
             sent_requests, step_requests, checked_results);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
design/onrk4_pkg.sv
design/onrk4_ctrl.sv
design/onrk4_dp.sv
design/oscillator_network_rk4_step_top.sv
tb/oscillator_network_rk4_step_checker.sv
tb/oscillator_network_rk4_step_top_tb.sv
